@@ design/pst_pkg.sv @@
// Package for the packed saturating counter table.
// Payload structs, state encoding, request, status and register codes.
// No dependencies.
package pst_pkg;

    localparam int VALUE_W = 13;
    localparam int KBITS_W = 4;
    localparam int COUNT_W = 8;
    localparam int BYTE_W  = 8;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;
    localparam logic [1:0] STAT_ZERO  = 2'd3;

    localparam logic CFG_MAX_VALUE    = 1'b0;
    localparam logic CFG_COUNTER_BITS = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [1:0]         status;
    } t_res;

    // Where one counter sits in the byte store
    typedef struct packed {
        logic               in_range;
        logic               b_odd;
        logic [2:0]         off;
        logic               has_hi;
        logic               straddle;
        logic [KBITS_W-1:0] k;
    } t_loc;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW
    } t_state;

endpackage

@@ design/pst_bank.sv @@
// One byte-wide bank of the counter store: synchronous write, registered read.
// Depends on nothing but its parameters.
module pst_bank #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/pst_locate.sv @@
// Counter locator: effective width, bit position, range check and bank row.
// Depends on pst_pkg.
module pst_locate #(
    parameter int STORE_BYTES = 1024,
    parameter int RW          = 9
) (
    input  logic [pst_pkg::VALUE_W-1:0] i_value,
    input  logic [pst_pkg::VALUE_W-1:0] i_max_value,
    input  logic [pst_pkg::KBITS_W-1:0] i_counter_bits,
    output pst_pkg::t_loc               o_loc,
    output logic [RW-1:0]               o_row
);

    localparam logic [20:0] STORE_BITS = 21'(STORE_BYTES * 8);
    localparam logic [17:0] STORE_LEN  = 18'(STORE_BYTES);

    logic [3:0]  k;
    logic [16:0] pos;
    logic [20:0] end_pos;
    logic [13:0] byte_ix;
    logic [19:0] row_wide;

    always_comb begin
        // zero counts as one bit, anything past eight as eight
        if (i_counter_bits == 4'd0) begin
            k = 4'd1;
        end else if (i_counter_bits > 4'd8) begin
            k = 4'd8;
        end else begin
            k = i_counter_bits;
        end
        pos      = 17'(i_value) * 17'(k);
        end_pos  = 21'(pos) + 21'(k);
        byte_ix  = pos[16:3];
        row_wide = 20'(pos[16:4]);

        o_loc.in_range = (i_value <= i_max_value) && (end_pos <= STORE_BITS);
        o_loc.b_odd    = pos[3];
        o_loc.off      = pos[2:0];
        o_loc.has_hi   = (18'(byte_ix) + 18'd1) < STORE_LEN;
        o_loc.straddle = (4'(pos[2:0]) + k) > 4'd8;
        o_loc.k        = k;
        o_row          = row_wide[RW-1:0];
    end

endmodule

@@ design/packed_saturating_counter_table.sv @@
// Packed saturating counter table: k-bit counters packed in a byte store.
// Flow: the start transfer reads the even/odd byte banks (registered read), the counter is
// written back in ST_RMW and the result strobe is registered from it; busy holds off the next request.
// Reset: registers take their reset values and a clearing pass zeroes the ceil(STORE_BYTES/2)
// rows of the store, one row of two bytes a cycle, with busy high. The receiver cannot stall.
module packed_saturating_counter_table #(
    parameter int STORE_BYTES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  pst_pkg::t_req               i_req,
    output logic                        o_done,
    output pst_pkg::t_res               o_res,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [pst_pkg::VALUE_W-1:0] i_cfg_data
);

    localparam int ROWS = (STORE_BYTES + 1) / 2;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    pst_pkg::t_state r_state, n_state;
    logic [RW-1:0]   r_clr, n_clr;
    pst_pkg::t_loc   r_loc;
    logic [1:0]      r_req_type;
    logic [RW-1:0]   r_even_row, r_odd_row;
    logic            r_done;
    pst_pkg::t_res   r_res;
    logic [pst_pkg::VALUE_W-1:0] r_max_value;
    logic [pst_pkg::KBITS_W-1:0] r_counter_bits;

    pst_pkg::t_loc   loc;
    logic [RW-1:0]   row;
    logic [RW-1:0]   even_raddr;
    logic            accept;

    logic [7:0]  even_q, odd_q, lo_q, hi_q;
    logic [15:0] word, new_word;
    logic [7:0]  mask8, cnt, new_cnt;
    logic [1:0]  status;
    logic        wr, hi_we;
    logic        even_we, odd_we;
    logic [RW-1:0] even_waddr, odd_waddr;
    logic [7:0]  even_wdata, odd_wdata;

    pst_locate #(
        .STORE_BYTES(STORE_BYTES),
        .RW         (RW)
    ) u_locate (
        .i_value       (i_req.value),
        .i_max_value   (r_max_value),
        .i_counter_bits(r_counter_bits),
        .o_loc         (loc),
        .o_row         (row)
    );

    assign busy       = (r_state != pst_pkg::ST_IDLE);
    assign accept     = start && !busy;
    // an odd start byte takes its upper byte from the next even row
    assign even_raddr = loc.b_odd ? row + RW'(1) : row;

    pst_bank #(.DEPTH(ROWS), .AW(RW)) u_even (
        .i_clk  (i_clk),
        .i_we   (even_we),
        .i_waddr(even_waddr),
        .i_wdata(even_wdata),
        .i_raddr(even_raddr),
        .o_rdata(even_q)
    );

    pst_bank #(.DEPTH(ROWS), .AW(RW)) u_odd (
        .i_clk  (i_clk),
        .i_we   (odd_we),
        .i_waddr(odd_waddr),
        .i_wdata(odd_wdata),
        .i_raddr(row),
        .o_rdata(odd_q)
    );

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            pst_pkg::ST_CLEAR: begin
                n_clr = r_clr + RW'(1);
                if (r_clr == LAST_ROW) begin
                    n_state = pst_pkg::ST_IDLE;
                end
            end
            pst_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = pst_pkg::ST_RMW;
                end
            end
            pst_pkg::ST_RMW: begin
                n_state = pst_pkg::ST_IDLE;
            end
            default: begin
                n_state = pst_pkg::ST_IDLE;
            end
        endcase
    end

    // Read, modify, write back; during ST_CLEAR both banks are written with zeros instead
    always_comb begin
        lo_q    = r_loc.b_odd ? odd_q : even_q;
        hi_q    = r_loc.has_hi ? (r_loc.b_odd ? even_q : odd_q) : 8'h00;
        word    = {hi_q, lo_q};
        mask8   = 8'((9'd1 << r_loc.k) - 9'd1);
        cnt     = 8'(word >> r_loc.off) & mask8;
        new_cnt = cnt;
        status  = pst_pkg::STAT_OK;
        case (r_req_type)
            pst_pkg::REQ_ADD: begin
                if (cnt == mask8) begin
                    status = pst_pkg::STAT_SAT;
                end else begin
                    new_cnt = cnt + 8'd1;
                end
            end
            pst_pkg::REQ_REMOVE: begin
                if (cnt == 8'd0) begin
                    status = pst_pkg::STAT_ZERO;
                end else begin
                    new_cnt = cnt - 8'd1;
                end
            end
            default: begin
                new_cnt = cnt;
            end
        endcase
        if (!r_loc.in_range) begin
            status  = pst_pkg::STAT_RANGE;
            new_cnt = 8'd0;
        end
        new_word = (word & ~(16'(mask8) << r_loc.off)) | (16'(new_cnt) << r_loc.off);
        wr = (r_state == pst_pkg::ST_RMW) && (status == pst_pkg::STAT_OK)
            && ((r_req_type == pst_pkg::REQ_ADD) || (r_req_type == pst_pkg::REQ_REMOVE));
        hi_we = wr && r_loc.has_hi && r_loc.straddle;

        if (r_state == pst_pkg::ST_CLEAR) begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_waddr = r_clr;
            odd_waddr  = r_clr;
            even_wdata = 8'h00;
            odd_wdata  = 8'h00;
        end else begin
            even_we    = r_loc.b_odd ? hi_we : wr;
            odd_we     = r_loc.b_odd ? wr : hi_we;
            even_waddr = r_even_row;
            odd_waddr  = r_odd_row;
            even_wdata = r_loc.b_odd ? new_word[15:8] : new_word[7:0];
            odd_wdata  = r_loc.b_odd ? new_word[7:0] : new_word[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= pst_pkg::ST_CLEAR;
            r_clr          <= '0;
            r_done         <= 1'b0;
            r_max_value    <= 13'd8191;
            r_counter_bits <= 4'd1;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= (r_state == pst_pkg::ST_RMW);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pst_pkg::CFG_MAX_VALUE:    r_max_value    <= i_cfg_data;
                    pst_pkg::CFG_COUNTER_BITS: r_counter_bits <= i_cfg_data[3:0];
                    default: begin
                        r_max_value <= r_max_value;
                    end
                endcase
            end
        end
    end

    // Payload: hold the located request for the write-back cycle and register the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_loc      <= loc;
            r_req_type <= i_req.req_type;
            r_even_row <= even_raddr;
            r_odd_row  <= row;
        end
        if (r_state == pst_pkg::ST_RMW) begin
            r_res.count  <= new_cnt;
            r_res.status <= status;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ design/pst_checker.sv @@
// Port-level checks for the packed saturating counter table, bound to the top level.
// Depends on pst_pkg and packed_saturating_counter_table.
module pst_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input pst_pkg::t_res o_res
);

    // every transfer in is followed by its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result strobe missing two cycles after start transfer");

    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.status == pst_pkg::STAT_RANGE)) |-> (o_res.count == 8'd0))
        else $error("out of range result with nonzero count");

    a_sat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.status == pst_pkg::STAT_SAT)) |-> (o_res.count != 8'd0))
        else $error("saturated add reported a zero count");

    a_clear_busy: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> busy)
        else $error("store not held busy after reset");

endmodule

bind packed_saturating_counter_table pst_checker u_pst_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_done (o_done),
    .o_res  (o_res)
);

@@ verif/packed_saturating_counter_table_test.sv @@
// Self-checking test of packed_saturating_counter_table: directed corner requests, then random
// request streams across counter widths and value limits, checked against a local byte-store model.
// Depends on pst_pkg and the table RTL.
module packed_saturating_counter_table_test;
    import pst_pkg::*;

    localparam int STORE_BYTES     = 1024;
    localparam int STORE_BITS      = STORE_BYTES * BYTE_W;
    localparam int MAX_VALUE_RESET = 8191;
    localparam int KBITS_RESET     = 1;
    localparam int QUIET_LIMIT     = 4000;
    localparam int RANDOM_PHASES   = 19;
    localparam int PHASE_ITEMS     = 100;
    localparam int MAX_GAP         = 19;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_req               i_req;
    logic               o_done;
    t_res               o_res;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [VALUE_W-1:0] i_cfg_data;

    // Local image of the table and its registers
    logic [BYTE_W-1:0]  shadow_bytes [STORE_BYTES];
    logic [VALUE_W-1:0] shadow_max_value;
    logic [KBITS_W-1:0] shadow_kbits;
    t_res               pending_results [$];
    int                 error_count = 0;
    int                 quiet_cycles = 0;
    bit                 back_to_back = 1'b0;

    packed_saturating_counter_table #(
        .STORE_BYTES(STORE_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int width_of(logic [KBITS_W-1:0] kbits);
        if (kbits == 0) return 1;
        if (kbits > COUNT_W) return COUNT_W;
        return int'(kbits);
    endfunction

    // Update the local store for one request and return the count and status it yields
    function automatic t_res apply_request(t_req r);
        int   k;
        int   mask;
        int   pos;
        int   byte_ix;
        int   off;
        int   window;
        int   cnt;
        logic has_hi;
        t_res res;
        k = width_of(shadow_kbits);
        mask = (1 << k) - 1;
        pos = int'(r.value) * k;
        res.count = '0;
        res.status = STAT_RANGE;
        if (r.value > shadow_max_value || pos + k > STORE_BITS) return res;
        byte_ix = pos / BYTE_W;
        off = pos % BYTE_W;
        has_hi = (byte_ix + 1) < STORE_BYTES;
        window = int'(shadow_bytes[byte_ix]);
        if (has_hi) window = window | (int'(shadow_bytes[byte_ix + 1]) << BYTE_W);
        cnt = (window >> off) & mask;
        res.status = STAT_OK;
        case (r.req_type)
            REQ_ADD: begin
                if (cnt >= mask) res.status = STAT_SAT;
                else cnt = cnt + 1;
            end
            REQ_REMOVE: begin
                if (cnt == 0) res.status = STAT_ZERO;
                else cnt = cnt - 1;
            end
            default: ;
        endcase
        if (res.status == STAT_OK && (r.req_type == REQ_ADD || r.req_type == REQ_REMOVE)) begin
            window = (window & ~(mask << off)) | (cnt << off);
            shadow_bytes[byte_ix] = window[BYTE_W-1:0];
            if (has_hi && off + k > BYTE_W) shadow_bytes[byte_ix + 1] = window[2*BYTE_W-1:BYTE_W];
        end
        res.count = cnt[COUNT_W-1:0];
        return res;
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        $display("%0t: %s", $time, msg);
    endtask

    // Check results, predict each accepted request and track register writes in one place
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
            shadow_max_value = VALUE_W'(MAX_VALUE_RESET);
            shadow_kbits = KBITS_W'(KBITS_RESET);
            pending_results.delete();
        end else begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    flag_error($sformatf("unexpected result: expected none, got count %0d status %0d",
                                         o_res.count, o_res.status));
                end else begin
                    want = pending_results.pop_front();
                    if (o_res.count !== want.count)
                        flag_error($sformatf("count mismatch: expected %0d, got %0d",
                                             want.count, o_res.count));
                    if (o_res.status !== want.status)
                        flag_error($sformatf("status mismatch: expected %0d, got %0d",
                                             want.status, o_res.status));
                end
            end
            if (start && !busy) pending_results.push_back(apply_request(i_req));
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAX_VALUE) shadow_max_value = i_cfg_data;
                else shadow_kbits = i_cfg_data[KBITS_W-1:0];
            end
        end
        if (i_rst_n && (o_done || (start && !busy) || i_cfg_we)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Hold start high until the transfer happens; leave it high for a following item
    task automatic send_request(logic [1:0] kind, logic [VALUE_W-1:0] elem);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{req_type: kind, value: elem};
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_config(logic [VALUE_W-1:0] kbits_word, logic [VALUE_W-1:0] limit);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_COUNTER_BITS;
        i_cfg_data <= kbits_word;
        @(posedge i_clk);
        i_cfg_idx <= CFG_MAX_VALUE;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One-bit counters straight after the clearing pass
    task automatic test_reset_defaults();
        drain_results();
        send_request(REQ_ADD, 13'd0);
        send_request(REQ_ADD, 13'd0);
        send_request(REQ_QUERY, 13'd0);
        send_request(REQ_REMOVE, 13'd8191);
        send_request(REQ_ADD, 13'd8191);
        send_request(REQ_QUERY, 13'd8191);
        send_request(REQ_SPARE, 13'd8191);
        send_request(REQ_REMOVE, 13'd8191);
    endtask

    // Three-bit counters cross byte boundaries; the last one would run past the store
    task automatic test_straddling_counters();
        set_config(13'd3, 13'd8191);
        send_request(REQ_ADD, 13'd2);
        send_request(REQ_ADD, 13'd2);
        send_request(REQ_REMOVE, 13'd2);
        send_request(REQ_QUERY, 13'd2);
        send_request(REQ_QUERY, 13'd2729);
        send_request(REQ_ADD, 13'd2730);
    endtask

    // Width register below one and above eight, value limit at zero, saturation at two bits
    task automatic test_width_limits();
        set_config(13'h1FFF, 13'd0);
        send_request(REQ_ADD, 13'd0);
        send_request(REQ_ADD, 13'd1);
        set_config(13'd8, 13'd8191);
        send_request(REQ_ADD, 13'd1023);
        send_request(REQ_QUERY, 13'd1024);
        set_config(13'd0, 13'd8191);
        send_request(REQ_ADD, 13'd7);
        send_request(REQ_QUERY, 13'd7);
        set_config(13'd2, 13'd8191);
        repeat (4) send_request(REQ_ADD, 13'd5);
    endtask

    // Mostly hammer a small window of values so counters climb, saturate and empty
    task automatic test_random_traffic();
        logic [KBITS_W-1:0] kbits;
        logic [VALUE_W-1:0] limit;
        logic [1:0]         kind;
        int                 top;
        int                 base;
        int                 add_pct;
        int                 sel;
        int                 elem;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    kbits = 4'd0;
                    limit = VALUE_W'(MAX_VALUE_RESET);
                end
                1: begin
                    kbits = 4'd8;
                    limit = VALUE_W'(MAX_VALUE_RESET);
                end
                2: begin
                    kbits = 4'd15;
                    limit = '0;
                end
                3: begin
                    kbits = 4'd1;
                    limit = VALUE_W'(MAX_VALUE_RESET);
                end
                default: begin
                    kbits = KBITS_W'($urandom_range(0, 15));
                    sel = $urandom_range(0, 3);
                    if (sel == 0) limit = VALUE_W'(MAX_VALUE_RESET);
                    else if (sel == 1) limit = VALUE_W'($urandom_range(0, 63));
                    else limit = VALUE_W'($urandom_range(0, MAX_VALUE_RESET));
                end
            endcase
            top = STORE_BITS / width_of(kbits) - 1;
            if (int'(limit) < top) top = int'(limit);
            base = $urandom_range(0, top);
            add_pct = $urandom_range(30, 80);
            set_config({VALUE_W'($urandom_range(0, 511)) << KBITS_W} | VALUE_W'(kbits), limit);
            back_to_back = (phase % 4 == 3);
            repeat (PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                if (sel < 5) kind = REQ_SPARE;
                else if (sel < 20) kind = REQ_QUERY;
                else if (sel < 20 + add_pct * 80 / 100) kind = REQ_ADD;
                else kind = REQ_REMOVE;
                sel = $urandom_range(0, 99);
                if (sel < 70) elem = base + $urandom_range(0, 7);
                else if (sel < 85) elem = $urandom_range(0, MAX_VALUE_RESET);
                else if (sel < 95) elem = top + $urandom_range(0, 2) - 1;
                else elem = $urandom_range(0, top);
                send_request(kind, VALUE_W'(elem));
            end
            back_to_back = 1'b0;
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_MAX_VALUE;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_straddling_counters();
        test_width_limits();
        test_random_traffic();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
